[sv/rts_pkg.sv]
// Shared types, constants and frame/sequence functions for the remote frame transmitter.
package rts_pkg;

  localparam int FRAME_BITS = 56;
  localparam int BIT_POS_W  = 6;
  localparam int CNT_W      = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOFT_SYNC    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAKE_PULSE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WAKE_SILENCE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_SILENCE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY          = 3'd6;

  // Register reset values
  localparam logic [11:0] HALF_BIT_RST     = 12'd640;
  localparam logic [15:0] SOFT_SYNC_RST    = 16'd4500;
  localparam logic [15:0] WAKE_PULSE_RST   = 16'd9415;
  localparam logic [16:0] WAKE_SILENCE_RST = 17'd89565;
  localparam logic [15:0] GAP_SILENCE_RST  = 16'd30415;
  localparam logic [2:0]  REPEAT_RST       = 3'd2;
  localparam logic [7:0]  KEY_RST          = 8'hAC;

  // Sync counts per frame
  localparam logic [2:0] FIRST_SYNCS  = 3'd2;
  localparam logic [2:0] REPEAT_SYNCS = 3'd7;

  // Operation codes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  typedef enum logic [8:0] {
    PH_IDLE    = 9'b000000001,
    PH_WAKE_HI = 9'b000000010,
    PH_WAKE_LO = 9'b000000100,
    PH_HW_HI   = 9'b000001000,
    PH_HW_LO   = 9'b000010000,
    PH_SOFT_HI = 9'b000100000,
    PH_SOFT_LO = 9'b001000000,
    PH_DATA    = 9'b010000000,
    PH_GAP     = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [11:0] half_bit_ticks;
    logic [15:0] soft_sync_ticks;
    logic [15:0] wakeup_pulse_ticks;
    logic [16:0] wakeup_silence_ticks;
    logic [15:0] interframe_silence_ticks;
    logic [2:0]  repeat_count;
    logic [7:0]  key_byte;
  } cfg_t;

  typedef struct packed {
    logic tx_level;
    logic busy_res;
    logic sequence_done;
    logic start_rejected;
  } result_t;

  typedef struct packed {
    phase_t               phase;
    logic [2:0]           frames_left;
    logic [2:0]           syncs_left;
    logic [BIT_POS_W-1:0] bit_position;
    logic                 second_half;
  } seq_t;

  // Length of a segment in ticks, read live from the registers
  function automatic logic [CNT_W-1:0] seg_len(phase_t ph, cfg_t c);
    logic [11:0]      half;
    logic [15:0]      sync_len;
    logic [CNT_W-1:0] len;
    half = (c.half_bit_ticks == 12'd0) ? 12'd1 : c.half_bit_ticks;
    sync_len = (c.soft_sync_ticks == 16'd0) ? 16'd1 : c.soft_sync_ticks;
    case (ph)
      PH_WAKE_HI:          len = {1'b0, c.wakeup_pulse_ticks};
      PH_WAKE_LO:          len = c.wakeup_silence_ticks;
      PH_HW_HI, PH_HW_LO:  len = {3'b000, half, 2'b00};
      PH_SOFT_HI:          len = {1'b0, sync_len};
      PH_SOFT_LO, PH_DATA: len = {5'b00000, half};
      PH_GAP:              len = {1'b0, c.interframe_silence_ticks};
      default:             len = 17'd1;
    endcase
    return len;
  endfunction

  // Move to the following segment
  function automatic seq_t advance(seq_t s);
    seq_t n;
    n = s;
    case (s.phase)
      PH_WAKE_HI: n.phase = PH_WAKE_LO;
      PH_WAKE_LO: n.phase = PH_HW_HI;
      PH_HW_HI:   n.phase = PH_HW_LO;
      PH_HW_LO: begin
        if (s.syncs_left > 3'd1) begin
          n.syncs_left = s.syncs_left - 3'd1;
          n.phase      = PH_HW_HI;
        end else begin
          n.syncs_left = 3'd0;
          n.phase      = PH_SOFT_HI;
        end
      end
      PH_SOFT_HI: n.phase = PH_SOFT_LO;
      PH_SOFT_LO: begin
        n.phase        = PH_DATA;
        n.bit_position = '0;
        n.second_half  = 1'b0;
      end
      PH_DATA: begin
        if (!s.second_half) begin
          n.second_half = 1'b1;
        end else begin
          n.second_half = 1'b0;
          if (s.bit_position < BIT_POS_W'(FRAME_BITS - 1)) begin
            n.bit_position = s.bit_position + 1'b1;
          end else begin
            n.bit_position = '0;
            n.phase        = PH_GAP;
          end
        end
      end
      PH_GAP: begin
        if (s.frames_left != 3'd0) begin
          n.frames_left = s.frames_left - 3'd1;
          n.syncs_left  = REPEAT_SYNCS;
          n.phase       = PH_HW_HI;
        end else begin
          n.phase = PH_IDLE;
        end
      end
      default: n.phase = PH_IDLE;
    endcase
    return n;
  endfunction

  // Pass over zero-length segments; at most two can follow one another
  function automatic seq_t skip_empty(seq_t s, cfg_t c);
    seq_t n;
    n = s;
    for (int i = 0; i < 2; i++) begin
      if (n.phase != PH_IDLE && seg_len(n.phase, c) == '0) begin
        n = advance(n);
      end
    end
    return n;
  endfunction

  // Build the seven-byte frame with checksum and chained XOR
  function automatic logic [FRAME_BITS-1:0] build_frame(logic [7:0] key, logic [23:0] addr,
                                                        logic [15:0] code, logic [3:0] btn);
    logic [7:0] b [7];
    logic [3:0] ck;
    b[0] = key;
    b[1] = {btn, 4'h0};
    b[2] = code[15:8];
    b[3] = code[7:0];
    b[4] = addr[23:16];
    b[5] = addr[15:8];
    b[6] = addr[7:0];
    ck = 4'h0;
    for (int i = 0; i < 7; i++) begin
      ck = ck ^ b[i][7:4] ^ b[i][3:0];
    end
    b[1] = {btn, ck};
    for (int i = 1; i < 7; i++) begin
      b[i] = b[i] ^ b[i-1];
    end
    return {b[0], b[1], b[2], b[3], b[4], b[5], b[6]};
  endfunction

endpackage

[sv/rts_item_if.sv]
// Input item channel: operation and start payload.
interface rts_item_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [23:0] address;
  logic [15:0] rolling_code;
  logic [3:0]  button;

  modport source (output valid, output operation, output address, output rolling_code,
                  output button, input ready);
  modport sink (input valid, input operation, input address, input rolling_code,
                input button, output ready);
endinterface

[sv/rts_result_if.sv]
// Result channel: line level and status flags per item.
interface rts_result_if;
  logic valid;
  logic ready;
  logic tx_level;
  logic busy_res;
  logic sequence_done;
  logic start_rejected;

  modport source (output valid, output tx_level, output busy_res, output sequence_done,
                  output start_rejected, input ready);
  modport sink (input valid, input tx_level, input busy_res, input sequence_done,
                input start_rejected, output ready);
endinterface

[sv/rts_cfg_if.sv]
// Configuration write channel: register index and data.
interface rts_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rts_pkg::CFG_IDX_W-1:0] index;
  logic [rts_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[sv/rts_remote_frame_transmitter.sv]
// Top level: configuration registers, sequencer and output buffer.
//
//   channel  | dir | payload                                          | transaction
//   item     | in  | operation, address, rolling_code, button         | valid & ready
//   result   | out | tx_level, busy_res, sequence_done, start_rejected| valid & ready
//   cfg      | in  | index, data                                      | valid & ready
//
// One item per clock while item.ready is high; each item's result is registered in the output buffer.
// The sequencer updates its state in the accepting cycle, so ticks run back to back.
// A two-entry output buffer keeps item.ready high until two results wait untaken.
// Reset clears the sequence and loads register defaults; no clearing pass is needed.
// cfg is always ready; an index beyond the register list is ignored.
module rts_remote_frame_transmitter (
  input logic         clk,
  input logic         rst,
  rts_item_if.sink    item,
  rts_result_if.source result,
  rts_cfg_if.sink     cfg
);

  rts_pkg::cfg_t    regs;
  rts_pkg::result_t seq_res;
  rts_pkg::result_t out_res;
  logic             accept;
  logic             push_ready;

  assign cfg.ready  = 1'b1;
  assign item.ready = push_ready;
  assign accept     = item.valid && push_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.half_bit_ticks           <= rts_pkg::HALF_BIT_RST;
      regs.soft_sync_ticks          <= rts_pkg::SOFT_SYNC_RST;
      regs.wakeup_pulse_ticks       <= rts_pkg::WAKE_PULSE_RST;
      regs.wakeup_silence_ticks     <= rts_pkg::WAKE_SILENCE_RST;
      regs.interframe_silence_ticks <= rts_pkg::GAP_SILENCE_RST;
      regs.repeat_count             <= rts_pkg::REPEAT_RST;
      regs.key_byte                 <= rts_pkg::KEY_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        rts_pkg::CFG_HALF_BIT:     regs.half_bit_ticks           <= cfg.data[11:0];
        rts_pkg::CFG_SOFT_SYNC:    regs.soft_sync_ticks          <= cfg.data[15:0];
        rts_pkg::CFG_WAKE_PULSE:   regs.wakeup_pulse_ticks       <= cfg.data[15:0];
        rts_pkg::CFG_WAKE_SILENCE: regs.wakeup_silence_ticks     <= cfg.data[16:0];
        rts_pkg::CFG_GAP_SILENCE:  regs.interframe_silence_ticks <= cfg.data[15:0];
        rts_pkg::CFG_REPEAT:       regs.repeat_count             <= cfg.data[2:0];
        rts_pkg::CFG_KEY:          regs.key_byte                 <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  rts_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .operation    (item.operation),
    .address      (item.address),
    .rolling_code (item.rolling_code),
    .button       (item.button),
    .cfg          (regs),
    .res          (seq_res)
  );

  rts_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (seq_res),
    .push_ready (push_ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_data   (out_res)
  );

  assign result.tx_level       = out_res.tx_level;
  assign result.busy_res       = out_res.busy_res;
  assign result.sequence_done  = out_res.sequence_done;
  assign result.start_rejected = out_res.start_rejected;

endmodule

[sv/rts_seq.sv]
// Sequencer: frame register, segment state and per-item result logic.
module rts_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic             operation,
  input  logic [23:0]      address,
  input  logic [15:0]      rolling_code,
  input  logic [3:0]       button,
  input  rts_pkg::cfg_t    cfg,
  output rts_pkg::result_t res
);

  rts_pkg::seq_t                   st;
  rts_pkg::seq_t                   st_next;
  logic [rts_pkg::CNT_W-1:0]       tick_counter;
  logic [rts_pkg::CNT_W-1:0]       tick_counter_next;
  logic [rts_pkg::FRAME_BITS-1:0]  frame;

  logic                            busy;
  logic                            level;
  logic [rts_pkg::CNT_W-1:0]       count_inc;
  logic [rts_pkg::BIT_POS_W-1:0]   bit_index;
  rts_pkg::seq_t                   start_st;

  assign busy      = (st.phase != rts_pkg::PH_IDLE);
  assign count_inc = tick_counter + 1'b1;
  assign bit_index = rts_pkg::BIT_POS_W'(rts_pkg::FRAME_BITS - 1) - st.bit_position;

  // Line level for the current segment
  always_comb begin
    case (st.phase)
      rts_pkg::PH_WAKE_HI, rts_pkg::PH_HW_HI, rts_pkg::PH_SOFT_HI: level = 1'b1;
      rts_pkg::PH_DATA: level = frame[bit_index] ^ ~st.second_half;
      default:          level = 1'b0;
    endcase
  end

  // Fresh sequence state on a start
  always_comb begin
    start_st.phase        = rts_pkg::PH_WAKE_HI;
    start_st.frames_left  = cfg.repeat_count;
    start_st.syncs_left   = rts_pkg::FIRST_SYNCS;
    start_st.bit_position = '0;
    start_st.second_half  = 1'b0;
  end

  // Next state and result for the item at the input
  always_comb begin
    st_next           = st;
    tick_counter_next = tick_counter;
    res               = '0;
    if (operation == rts_pkg::OP_START) begin
      if (busy) begin
        res.start_rejected = 1'b1;
      end else begin
        st_next           = rts_pkg::skip_empty(start_st, cfg);
        tick_counter_next = '0;
      end
    end else if (busy) begin
      res.tx_level = level;
      if (count_inc >= rts_pkg::seg_len(st.phase, cfg)) begin
        st_next           = rts_pkg::skip_empty(rts_pkg::advance(st), cfg);
        tick_counter_next = '0;
        res.sequence_done = (st_next.phase == rts_pkg::PH_IDLE);
      end else begin
        tick_counter_next = count_inc;
      end
    end
    res.busy_res = (st_next.phase != rts_pkg::PH_IDLE);
  end

  // Sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase        <= rts_pkg::PH_IDLE;
      st.frames_left  <= '0;
      st.syncs_left   <= '0;
      st.bit_position <= '0;
      st.second_half  <= 1'b0;
      tick_counter    <= '0;
    end else if (accept) begin
      st           <= st_next;
      tick_counter <= tick_counter_next;
    end
  end

  // Frame register, loaded on an accepted start
  always_ff @(posedge clk) begin
    if (accept && operation == rts_pkg::OP_START && !busy) begin
      frame <= rts_pkg::build_frame(cfg.key_byte, address, rolling_code, button);
    end
  end

  a_idle_counter_clear: assert property (@(posedge clk) disable iff (rst)
    st.phase == rts_pkg::PH_IDLE |-> tick_counter == '0)
    else $error("tick counter not cleared while idle");

  a_sync_left: assert property (@(posedge clk) disable iff (rst)
    (st.phase == rts_pkg::PH_HW_HI || st.phase == rts_pkg::PH_HW_LO) |-> st.syncs_left != '0)
    else $error("hardware sync with no syncs left");

  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    st.phase == rts_pkg::PH_DATA |-> st.bit_position <= rts_pkg::BIT_POS_W'(rts_pkg::FRAME_BITS - 1))
    else $error("bit position past end of frame");

  a_reject_holds: assert property (@(posedge clk) disable iff (rst)
    accept && res.start_rejected |=> $stable(st.phase) && $stable(frame))
    else $error("rejected start changed the sequence");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    accept && res.sequence_done |=> st.phase == rts_pkg::PH_IDLE)
    else $error("sequence done but not idle");

endmodule

[sv/rts_skid.sv]
// Two-entry output buffer: result register plus skid register.
module rts_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rts_pkg::result_t push_data,
  output logic             push_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output rts_pkg::result_t out_data
);

  logic             skid_valid;
  rts_pkg::result_t skid_data;
  logic             pop;

  assign push_ready = !skid_valid;
  assign pop        = out_valid && out_ready;

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else if (!push) begin
          out_valid <= 1'b0;
        end
      end else if (push) begin
        if (out_valid) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

endmodule

[sim/rts_frame_checker.sv]
// Checker for the remote frame transmitter: predicts every line result and compares it.
`timescale 1ns / 100ps
module rts_frame_checker (
  input  logic  clk,
  input  logic  rst,
  rts_item_if   item,
  rts_result_if result,
  rts_cfg_if    cfg,
  output int    errors,
  output int    checked,
  output int    finished,
  output logic  busy,
  output int    pending
);

  localparam int REPORT_LIMIT = 40;

  // Predicted register file and sequencer state
  rts_pkg::cfg_t                  regs;
  rts_pkg::phase_t                ph;
  logic [rts_pkg::FRAME_BITS-1:0] frame;
  logic [rts_pkg::CNT_W-1:0]      ticks;
  logic [rts_pkg::BIT_POS_W-1:0]  bitpos;
  logic [2:0]                     syncs_left;
  logic [2:0]                     frames_left;
  logic                           late_half;

  // Line results still owed by the block, oldest first
  rts_pkg::result_t line_results_due[$];

  // Ticks a segment lasts under the current register values
  function automatic int unsigned span(rts_pkg::phase_t p);
    int unsigned half;
    half = (regs.half_bit_ticks == 0) ? 1 : regs.half_bit_ticks;
    case (p)
      rts_pkg::PH_WAKE_HI: return regs.wakeup_pulse_ticks;
      rts_pkg::PH_WAKE_LO: return regs.wakeup_silence_ticks;
      rts_pkg::PH_HW_HI, rts_pkg::PH_HW_LO: return 4 * half;
      rts_pkg::PH_SOFT_HI: return (regs.soft_sync_ticks == 0) ? 1 : regs.soft_sync_ticks;
      rts_pkg::PH_SOFT_LO, rts_pkg::PH_DATA: return half;
      rts_pkg::PH_GAP:     return regs.interframe_silence_ticks;
      default:             return 1;
    endcase
  endfunction

  // Key, button/checksum, code and address, then the chained XOR over the bytes
  function automatic logic [rts_pkg::FRAME_BITS-1:0] encode_frame(
      logic [7:0] key, logic [23:0] addr, logic [15:0] code, logic [3:0] btn);
    logic [rts_pkg::FRAME_BITS-1:0] plain;
    logic [rts_pkg::FRAME_BITS-1:0] coded;
    logic [3:0]                     sum;
    logic [7:0]                     prev;
    plain = {key, btn, 4'h0, code, addr};
    sum = 4'h0;
    for (int n = 0; n < rts_pkg::FRAME_BITS / 4; n++) begin
      sum = sum ^ plain[n*4 +: 4];
    end
    plain[43:40] = sum;
    coded = plain;
    prev = plain[rts_pkg::FRAME_BITS-1 -: 8];
    for (int i = 1; i < 7; i++) begin
      prev = plain[rts_pkg::FRAME_BITS-1-8*i -: 8] ^ prev;
      coded[rts_pkg::FRAME_BITS-1-8*i -: 8] = prev;
    end
    return coded;
  endfunction

  // Line level for the tick now being spent
  function automatic logic level_now();
    case (ph)
      rts_pkg::PH_WAKE_HI, rts_pkg::PH_HW_HI, rts_pkg::PH_SOFT_HI: return 1'b1;
      rts_pkg::PH_DATA: return frame[rts_pkg::FRAME_BITS-1-bitpos] ^ ~late_half;
      default: return 1'b0;
    endcase
  endfunction

  // Step to the segment that follows the current one
  function automatic void next_segment();
    ticks = '0;
    case (ph)
      rts_pkg::PH_WAKE_HI: ph = rts_pkg::PH_WAKE_LO;
      rts_pkg::PH_WAKE_LO: ph = rts_pkg::PH_HW_HI;
      rts_pkg::PH_HW_HI:   ph = rts_pkg::PH_HW_LO;
      rts_pkg::PH_HW_LO: begin
        if (syncs_left > 1) begin
          syncs_left--;
          ph = rts_pkg::PH_HW_HI;
        end else begin
          syncs_left = '0;
          ph = rts_pkg::PH_SOFT_HI;
        end
      end
      rts_pkg::PH_SOFT_HI: ph = rts_pkg::PH_SOFT_LO;
      rts_pkg::PH_SOFT_LO: begin
        ph = rts_pkg::PH_DATA;
        bitpos = '0;
        late_half = 1'b0;
      end
      rts_pkg::PH_DATA: begin
        if (!late_half) begin
          late_half = 1'b1;
        end else begin
          late_half = 1'b0;
          if (bitpos < rts_pkg::FRAME_BITS - 1) begin
            bitpos++;
          end else begin
            bitpos = '0;
            ph = rts_pkg::PH_GAP;
          end
        end
      end
      rts_pkg::PH_GAP: begin
        if (frames_left > 0) begin
          frames_left--;
          syncs_left = rts_pkg::REPEAT_SYNCS;
          ph = rts_pkg::PH_HW_HI;
        end else begin
          ph = rts_pkg::PH_IDLE;
        end
      end
      default: ph = rts_pkg::PH_IDLE;
    endcase
  endfunction

  function automatic void skip_zero_segments();
    while (ph != rts_pkg::PH_IDLE && span(ph) == 0) next_segment();
  endfunction

  // Expected result of one accepted item; updates the predicted state
  function automatic rts_pkg::result_t predict_line_tick(logic op, logic [23:0] addr,
                                                         logic [15:0] code, logic [3:0] btn);
    rts_pkg::result_t r;
    logic             was_busy;
    r = '0;
    was_busy = (ph != rts_pkg::PH_IDLE);
    if (op == rts_pkg::OP_START) begin
      if (was_busy) begin
        r.start_rejected = 1'b1;
      end else begin
        frame = encode_frame(regs.key_byte, addr, code, btn);
        ph = rts_pkg::PH_WAKE_HI;
        ticks = '0;
        bitpos = '0;
        late_half = 1'b0;
        syncs_left = rts_pkg::FIRST_SYNCS;
        frames_left = regs.repeat_count;
        skip_zero_segments();
      end
    end else if (was_busy) begin
      r.tx_level = level_now();
      ticks = ticks + 1'b1;
      if (ticks >= span(ph)) begin
        next_segment();
        skip_zero_segments();
        if (ph == rts_pkg::PH_IDLE) begin
          r.sequence_done = 1'b1;
          finished++;
        end
      end
    end
    r.busy_res = (ph != rts_pkg::PH_IDLE);
    return r;
  endfunction

  function automatic void check_field(string name, logic want, logic got);
    if (got !== want) begin
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %b, got %b", $time, name, want, got);
    end
  endfunction

  // Watch all three channels at the rising edge
  always @(posedge clk) begin : watch
    rts_pkg::result_t want;
    rts_pkg::result_t got;
    if (rst) begin
      regs = {rts_pkg::HALF_BIT_RST, rts_pkg::SOFT_SYNC_RST, rts_pkg::WAKE_PULSE_RST,
              rts_pkg::WAKE_SILENCE_RST, rts_pkg::GAP_SILENCE_RST, rts_pkg::REPEAT_RST,
              rts_pkg::KEY_RST};
      ph = rts_pkg::PH_IDLE;
      frame = '0;
      ticks = '0;
      bitpos = '0;
      syncs_left = '0;
      frames_left = '0;
      late_half = 1'b0;
      line_results_due.delete();
    end else begin
      // register writes
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          rts_pkg::CFG_HALF_BIT:     regs.half_bit_ticks = cfg.data[11:0];
          rts_pkg::CFG_SOFT_SYNC:    regs.soft_sync_ticks = cfg.data[15:0];
          rts_pkg::CFG_WAKE_PULSE:   regs.wakeup_pulse_ticks = cfg.data[15:0];
          rts_pkg::CFG_WAKE_SILENCE: regs.wakeup_silence_ticks = cfg.data[16:0];
          rts_pkg::CFG_GAP_SILENCE:  regs.interframe_silence_ticks = cfg.data[15:0];
          rts_pkg::CFG_REPEAT:       regs.repeat_count = cfg.data[2:0];
          rts_pkg::CFG_KEY:          regs.key_byte = cfg.data[7:0];
          default: ;
        endcase
      end
      // result transactions against the oldest expectation
      if (result.valid && result.ready) begin
        got.tx_level = result.tx_level;
        got.busy_res = result.busy_res;
        got.sequence_done = result.sequence_done;
        got.start_rejected = result.start_rejected;
        if (line_results_due.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%0t: unexpected result, expected none, got %b", $time, got);
        end else begin
          want = line_results_due.pop_front();
          check_field("tx_level", want.tx_level, got.tx_level);
          check_field("busy_res", want.busy_res, got.busy_res);
          check_field("sequence_done", want.sequence_done, got.sequence_done);
          check_field("start_rejected", want.start_rejected, got.start_rejected);
          checked++;
        end
      end
      // item transactions
      if (item.valid && item.ready)
        line_results_due.push_back(predict_line_tick(item.operation, item.address,
                                                     item.rolling_code, item.button));
    end
    busy = (ph != rts_pkg::PH_IDLE);
    pending = line_results_due.size();
  end

endmodule

[sim/tb_rts_remote_frame_transmitter.sv]
// Testbench top for the remote frame transmitter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_rts_remote_frame_transmitter;

  localparam int QUIET_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 600;
  // index with no register behind it
  localparam logic [rts_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_BEAT} rx_mode_t;

  logic clk;
  logic rst;

  rts_item_if   item_ch();
  rts_result_if res_ch();
  rts_cfg_if    cfg_ch();

  int   errors;
  int   checked;
  int   finished;
  int   pending;
  logic busy;

  bit quick;         // no idling on either side
  bit hold_request;  // asks the receiver for one long hold-off
  int burst_left;
  int items_sent;
  int starts_sent;
  int writes_sent;

  rts_remote_frame_transmitter dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  rts_frame_checker line_check (
    .clk      (clk),
    .rst      (rst),
    .item     (item_ch),
    .result   (res_ch),
    .cfg      (cfg_ch),
    .errors   (errors),
    .checked  (checked),
    .finished (finished),
    .busy     (busy),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: stall pattern drawn anew from four modes whenever a mode runs out, plus one long hold-off
  initial begin : receiver
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    mode = RX_OPEN;
    mode_left = 0;
    hold_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (quick) begin
        res_ch.ready <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(10, 150);
        end
        mode_left--;
        case (mode)
          RX_OPEN:  res_ch.ready <= 1'b1;
          RX_LIGHT: res_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_HEAVY: res_ch.ready <= ($urandom_range(0, 3) == 0);
          default:  res_ch.ready <= ((mode_left % 3) != 0);
        endcase
      end
    end
  end

  // Watchdog: ends the run after too many cycles without any transaction
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
    $display("rts_remote_frame_transmitter test failed");
    $finish;
  end

  // Offer one item; the sender runs in bursts with random gaps
  task automatic offer(input logic op, input logic [23:0] addr, input logic [15:0] code,
                       input logic [3:0] btn);
    if (!quick && burst_left <= 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
    end
    item_ch.valid        <= 1'b1;
    item_ch.operation    <= op;
    item_ch.address      <= addr;
    item_ch.rolling_code <= code;
    item_ch.button       <= btn;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    items_sent++;
    if (op == rts_pkg::OP_START) starts_sent++;
  endtask

  // Tick with junk in the unused start fields
  task automatic tick();
    offer(rts_pkg::OP_TICK, 24'($urandom), 16'($urandom), 4'($urandom));
  endtask

  // Stop offering until all results are in; optionally until the line is idle too
  task automatic drain(input bit to_idle);
    item_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0 || (to_idle && busy));
    if (to_idle) repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [rts_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rts_pkg::CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    writes_sent++;
  endtask

  function automatic rts_pkg::cfg_t settings(int half, int soft_hi, int pulse, int silence,
                                             int gap, int reps, int key);
    rts_pkg::cfg_t s;
    s.half_bit_ticks = 12'(half);
    s.soft_sync_ticks = 16'(soft_hi);
    s.wakeup_pulse_ticks = 16'(pulse);
    s.wakeup_silence_ticks = 17'(silence);
    s.interframe_silence_ticks = 16'(gap);
    s.repeat_count = 3'(reps);
    s.key_byte = 8'(key);
    return s;
  endfunction

  // Short segments so that many sequences fit in the run
  function automatic rts_pkg::cfg_t brief_settings();
    return settings(($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : $urandom_range(0, 1),
                    $urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 6),
                    $urandom_range(0, 6),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(2, 7) : $urandom_range(0, 1),
                    $urandom_range(0, 255));
  endfunction

  // Write all registers; if dirty, junk goes above each register narrower than the data and to the spare index
  task automatic write_all(input rts_pkg::cfg_t s, input bit dirty);
    logic [rts_pkg::CFG_DATA_W-1:0] hi;
    hi = dirty ? rts_pkg::CFG_DATA_W'($urandom) : '0;
    write_reg(rts_pkg::CFG_HALF_BIT, {hi[16:12], s.half_bit_ticks});
    write_reg(rts_pkg::CFG_SOFT_SYNC, {hi[16], s.soft_sync_ticks});
    write_reg(rts_pkg::CFG_WAKE_PULSE, {hi[16], s.wakeup_pulse_ticks});
    write_reg(rts_pkg::CFG_WAKE_SILENCE, s.wakeup_silence_ticks);
    write_reg(rts_pkg::CFG_GAP_SILENCE, {hi[16], s.interframe_silence_ticks});
    write_reg(rts_pkg::CFG_REPEAT, {hi[16:3], s.repeat_count});
    write_reg(rts_pkg::CFG_KEY, {hi[16:8], s.key_byte});
    if (dirty) write_reg(CFG_SPARE, rts_pkg::CFG_DATA_W'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  // Write all registers once the line is idle
  task automatic load_settings(input rts_pkg::cfg_t s, input bit dirty);
    drain(1'b1);
    write_all(s, dirty);
  endtask

  // Rewrite the registers mid-sequence once nothing is in flight; long segments end early
  task automatic trim_live(input rts_pkg::cfg_t s);
    drain(1'b0);
    write_all(s, 1'b0);
  endtask

  // One start, then ticks until the predicted sequence ends, with stray starts mixed in
  task automatic run_sequence(input logic [23:0] addr, input logic [15:0] code,
                              input logic [3:0] btn, input bit refuse_at_once, input bit squeeze,
                              input int cut_at, input rts_pkg::cfg_t cut_to);
    int n;
    offer(rts_pkg::OP_START, addr, code, btn);
    if (refuse_at_once) offer(rts_pkg::OP_START, 24'hFFFFFF, 16'hFFFF, 4'hF);
    n = 0;
    while (busy) begin
      if (!quick && $urandom_range(0, 99) == 0)
        offer(rts_pkg::OP_START, 24'($urandom), 16'($urandom), 4'($urandom));
      else
        tick();
      n++;
      if (cut_at > 0 && n == cut_at) trim_live(cut_to);
      if (squeeze && n == 40) hold_request = 1'b1;
      if (squeeze && n == 120) drain(1'b0);
    end
    repeat ($urandom_range(0, 2)) tick();
  endtask

  initial begin : stimulus
    int mark;
    item_ch.valid = 1'b0;
    item_ch.operation = rts_pkg::OP_TICK;
    item_ch.address = '0;
    item_ch.rolling_code = '0;
    item_ch.button = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = rts_pkg::CFG_HALF_BIT;
    cfg_ch.data = '0;
    rst = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset values of wake-up pulse, repeat count and key; zero half bit, soft sync, wake-up silence and gap silence.
    // The wake-up pulse is cut short by a live write after a few dozen ticks.
    write_reg(rts_pkg::CFG_HALF_BIT, '0);
    write_reg(rts_pkg::CFG_SOFT_SYNC, '0);
    write_reg(rts_pkg::CFG_WAKE_SILENCE, '0);
    write_reg(rts_pkg::CFG_GAP_SILENCE, '0);
    cfg_ch.valid <= 1'b0;
    tick();
    tick();
    run_sequence(24'h000000, 16'h0000, 4'h0, 1'b1, 1'b0, 60,
                 settings(0, 0, 1, 0, 0, rts_pkg::REPEAT_RST, rts_pkg::KEY_RST));

    // No wake-up pulse, no closing silence: done lands on the last data half bit
    load_settings(settings(1, 1, 0, 1, 0, 0, 8'h00), 1'b0);
    run_sequence(24'hFFFFFF, 16'hFFFF, 4'hF, 1'b0, 1'b0, 0, '0);

    // Most repeats, key all ones, no wake-up silence
    load_settings(settings(1, 3, 1, 0, 2, 7, 8'hFF), 1'b0);
    run_sequence(24'($urandom), 16'($urandom), 4'h8, 1'b1, 1'b0, 0, '0);

    // Random sequences with short segments
    mark = items_sent;
    for (int n = 0; items_sent - mark < RANDOM_ITEMS; n++) begin
      load_settings(brief_settings(), $urandom_range(0, 2) == 0);
      repeat ($urandom_range(0, 3)) tick();
      run_sequence(24'($urandom), 16'($urandom), 4'($urandom), 1'b0, n == 0, 0, '0);
    end

    // Every length register at its maximum, driven without idling, then trimmed live
    load_settings(settings(4095, 65535, 65535, 131071, 65535, 0, $urandom_range(0, 255)), 1'b1);
    quick = 1'b1;
    run_sequence(24'($urandom), 16'($urandom), 4'($urandom), 1'b0, 1'b0, 150,
                 brief_settings());
    quick = 1'b0;

    drain(1'b1);
    repeat (8) @(negedge clk);
    $display("Run covered %0d items (%0d starts), %0d register writes, %0d results checked.",
             items_sent, starts_sent, writes_sent, checked);
    $display("%0d sequences ended; lengths ran from zero to register maxima, long ones cut live.",
             finished);
    if (errors == 0)
      $display("rts_remote_frame_transmitter test passed");
    else
      $display("rts_remote_frame_transmitter test failed");
    $finish;
  end

endmodule

[sim.f]
sv/rts_pkg.sv
sv/rts_item_if.sv
sv/rts_result_if.sv
sv/rts_cfg_if.sv
sv/rts_seq.sv
sv/rts_skid.sv
sv/rts_remote_frame_transmitter.sv
sim/rts_frame_checker.sv
sim/tb_rts_remote_frame_transmitter.sv
